// ===== rtl/mrsp_pkg.sv =====
`default_nettype none
package mrsp_pkg;

  localparam logic [7:0] RealTimeMin = 8'hF8;
  localparam logic [7:0] StatusBit   = 8'h80;
  localparam logic [7:0] KindMask    = 8'hF0;
  localparam logic [7:0] KindProgram = 8'hC0;
  localparam logic [7:0] KindChPress = 8'hD0;
  localparam logic [7:0] KindBend    = 8'hE0;

  // Number of data bytes that a status byte calls for.
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } data_cnt_e;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0]  midi_byte;
    logic        packet_end;
    logic [63:0] packet_time;
  } item_t;

  typedef struct packed {
    logic [7:0]  event_status;
    logic [7:0]  event_data1;
    logic [7:0]  event_data2;
    logic [63:0] event_time;
  } event_t;

  function automatic data_cnt_e data_count(logic [7:0] status);
    logic [7:0] kind;
    data_cnt_e  cnt;
    kind = status & KindMask;
    if (kind == KindProgram || kind == KindChPress) begin
      cnt = CNT_ONE;
    end else if (kind >= StatusBit && kind <= KindBend) begin
      cnt = CNT_TWO;
    end else begin
      cnt = CNT_NONE;
    end
    return cnt;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mrsp_stream_if.sv =====
`default_nettype none
interface mrsp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  midi_byte;
  logic        packet_end;
  logic [63:0] packet_time;

  modport source (output valid, output midi_byte, output packet_end, output packet_time,
                  input ready);
  modport sink (input valid, input midi_byte, input packet_end, input packet_time,
                output ready);
endinterface

interface mrsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  event_status;
  logic [7:0]  event_data1;
  logic [7:0]  event_data2;
  logic [63:0] event_time;

  modport source (output valid, output event_status, output event_data1,
                  output event_data2, output event_time, input ready);
  modport sink (input valid, input event_status, input event_data1,
                input event_data2, input event_time, output ready);
endinterface
`default_nettype wire

// ===== rtl/midi_running_status_parser.sv =====
// A byte is accepted into the input register and then taken by the parser; the event that
// it completes is then held in the event register until the output takes it.
// Throughput: one byte per cycle while the event output is taken; the parser state
// updates in a single pass between the input register and the event register.
// Reset (asynchronous, active low) clears the running status, the phase, the held data
// byte, the skip flag and both valid flags.
`default_nettype none
module midi_running_status_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mrsp_in_if.sink   in_chan_i,
  mrsp_out_if.source out_chan_o
);
  import mrsp_pkg::*;

  item_t  up_item;
  item_t  core_item;
  event_t ev;
  logic   core_valid;
  logic   core_ready;

  assign up_item.midi_byte   = in_chan_i.midi_byte;
  assign up_item.packet_end  = in_chan_i.packet_end;
  assign up_item.packet_time = in_chan_i.packet_time;

  mrsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_chan_i.valid),
    .up_ready_o (in_chan_i.ready),
    .up_item_i  (up_item),
    .dn_valid_o (core_valid),
    .dn_ready_i (core_ready),
    .dn_item_o  (core_item)
  );

  mrsp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (core_valid),
    .item_ready_o (core_ready),
    .item_i       (core_item),
    .ev_valid_o   (out_chan_o.valid),
    .ev_ready_i   (out_chan_o.ready),
    .ev_o         (ev)
  );

  assign out_chan_o.event_status = ev.event_status;
  assign out_chan_o.event_data1  = ev.event_data1;
  assign out_chan_o.event_data2  = ev.event_data2;
  assign out_chan_o.event_time   = ev.event_time;

`ifndef ASSERT_OFF
  // A held event blocks the parser, so no byte can slip past it.
  a_stall_on_held_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan_o.valid && !out_chan_o.ready) |-> !core_ready)
    else $error("parser took a byte while an event was held");

  // A buffered byte the parser did not take stays buffered.
  a_buffer_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (core_valid && !core_ready) |=> core_valid)
    else $error("buffered byte lost while parser stalled");

  // Only channel message status bytes are ever reported.
  a_channel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid |-> (out_chan_o.event_status[7] &&
                          (out_chan_o.event_status[7:4] != 4'hF)))
    else $error("event carries a non-channel status");
`endif

endmodule
`default_nettype wire

// ===== rtl/mrsp_in_reg.sv =====
`default_nettype none
module mrsp_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          up_valid_i,
  output logic               up_ready_o,
  input  wire mrsp_pkg::item_t up_item_i,
  output logic               dn_valid_o,
  input  wire logic          dn_ready_i,
  output mrsp_pkg::item_t    dn_item_o
);
  import mrsp_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      item_q <= up_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mrsp_parse.sv =====
`default_nettype none
module mrsp_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  output logic                 item_ready_o,
  input  wire mrsp_pkg::item_t item_i,
  output logic                 ev_valid_o,
  input  wire logic            ev_ready_i,
  output mrsp_pkg::event_t     ev_o
);
  import mrsp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [7:0] held_q, held_d;
  logic       skip_q, skip_d;
  logic       ev_valid_q;
  event_t     ev_q;

  logic       take;
  logic       emit;
  logic [7:0] emit_d1;
  logic [7:0] emit_d2;
  logic [7:0] b;

  assign b            = item_i.midi_byte;
  assign item_ready_o = !ev_valid_q || ev_ready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    phase_d  = phase_q;
    status_d = status_q;
    held_d   = held_q;
    skip_d   = skip_q;
    emit     = 1'b0;
    emit_d1  = b;
    emit_d2  = 8'h00;
    if (!skip_q) begin
      case (phase_q)
        PH_FIRST: begin
          if (data_count(status_q) == CNT_ONE) begin
            emit    = 1'b1;
            phase_d = PH_WAIT;
          end else begin
            held_d  = b;
            phase_d = PH_SECOND;
          end
        end
        PH_SECOND: begin
          emit    = 1'b1;
          emit_d1 = held_q;
          emit_d2 = b;
          phase_d = PH_WAIT;
        end
        default: begin
          // Message start; an unused phase code counts as waiting too.
          if (b >= RealTimeMin) begin
            phase_d = PH_WAIT;
          end else if ((b & StatusBit) != 8'h00) begin
            status_d = b;
            if (data_count(b) == CNT_NONE) begin
              skip_d  = 1'b1;
              phase_d = PH_WAIT;
            end else begin
              phase_d = PH_FIRST;
            end
          end else begin
            case (data_count(status_q))
              CNT_ONE: begin
                emit    = 1'b1;
                phase_d = PH_WAIT;
              end
              CNT_TWO: begin
                held_d  = b;
                phase_d = PH_SECOND;
              end
              default: begin
                skip_d  = 1'b1;
                phase_d = PH_WAIT;
              end
            endcase
          end
        end
      endcase
    end
    // Packet end drops any partial message; running status is kept.
    if (item_i.packet_end) begin
      phase_d = PH_WAIT;
      skip_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      status_q   <= 8'h00;
      held_q     <= 8'h00;
      skip_q     <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q  <= phase_d;
        status_q <= status_d;
        held_q   <= held_d;
        skip_q   <= skip_d;
      end
      if (take && emit) begin
        ev_valid_q <= 1'b1;
      end else if (ev_ready_i) begin
        ev_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      ev_q.event_status <= status_q;
      ev_q.event_data1  <= emit_d1;
      ev_q.event_data2  <= emit_d2;
      ev_q.event_time   <= item_i.packet_time;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule
`default_nettype wire
